[hdl/tcbw_pkg.sv]
`default_nettype none

package tcbw_pkg;

	// request codes; 6 and 7 carry no meaning and are dropped
	typedef enum logic [2:0] {
		REQ_PUT        = 3'd0,
		REQ_MOVE       = 3'd1,
		REQ_CLEAR      = 3'd2,
		REQ_SET_REMAP  = 3'd3,
		REQ_CLR_REMAPS = 3'd4,
		REQ_READ       = 3'd5
	} req_code_t;

	typedef enum logic [2:0] {
		CFG_ROWS = 3'd0,
		CFG_COLS = 3'd1,
		CFG_FORE = 3'd2,
		CFG_BACK = 3'd3,
		CFG_SKIP = 3'd4
	} cfg_index_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_PUT,
		ST_READ,
		ST_CLEAR
	} state_t;

	localparam logic [7:0]  SPACE_CHAR   = 8'h20;
	localparam logic [7:0]  NEWLINE_CHAR = 8'h0A;
	localparam logic [14:0] OFFSET_LIMIT = 15'h7FFF;

	// visible sizes are held to 9 bits so that 256 fits
	localparam int VIS_W = 9;

endpackage

`default_nettype wire

[hdl/tcbw_req_if.sv]
`default_nettype none

interface tcbw_req_if;
	logic               valid;
	logic               ready;
	logic        [2:0]  req_type;
	logic        [7:0]  char_code;
	logic        [7:0]  remap_target;
	logic signed [15:0] pos_x;
	logic signed [15:0] pos_y;

	modport source (
		output valid, req_type, char_code, remap_target, pos_x, pos_y,
		input  ready
	);

	modport sink (
		input  valid, req_type, char_code, remap_target, pos_x, pos_y,
		output ready
	);
endinterface

`default_nettype wire

[hdl/tcbw_cell_if.sv]
`default_nettype none

interface tcbw_cell_if;
	logic       valid;
	logic       ready;
	logic [7:0] cell_char;
	logic [7:0] cell_attr;
	logic       cell_in_range;

	modport source (
		output valid, cell_char, cell_attr, cell_in_range,
		input  ready
	);

	modport sink (
		input  valid, cell_char, cell_attr, cell_in_range,
		output ready
	);
endinterface

`default_nettype wire

[hdl/tcbw_ram.sv]
`default_nettype none

module tcbw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8192,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output      logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read data holds while re is low
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[hdl/text_cell_buffer_writer_unit.sv]
`default_nettype none

// Put char: remap lookup, then cell write; read cell: RAM read, then the output register,
// held back only while an earlier result is still waiting there. Move and remap edits take
// effect as the request is taken. Clear: one cell write per cycle over visible rows * visible
// columns. After arst_n the cell store is swept to zero, one entry a cycle, MAX_ROWS*MAX_COLS
// entries (8192 at default size); requests wait, configuration writes are taken throughout.
// Reset clears cursor, offset and remap valid bits at once; config registers get reset values.
module text_cell_buffer_writer_unit #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 128
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [2:0] cfg_index,
	input  wire logic [7:0] cfg_data,
	tcbw_req_if.sink        req,
	tcbw_cell_if.source     rsp
);

	import tcbw_pkg::*;

	localparam int DEPTH = MAX_ROWS * MAX_COLS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

	localparam logic [VIS_W-1:0] MAXR_V = VIS_W'(MAX_ROWS);
	localparam logic [VIS_W-1:0] MAXC_V = VIS_W'(MAX_COLS);
	localparam logic [AW-1:0]    COLS_A = AW'(MAX_COLS);
	localparam logic [AW-1:0]    LAST_A = AW'(DEPTH - 1);

	// ---------------------------------------------------------------- helpers
	// position check on sign-extended coordinates
	function automatic logic on_scr(input logic [16:0] r, input logic [16:0] c,
			input logic [VIS_W-1:0] vr, input logic [VIS_W-1:0] vc);
		on_scr = !r[16] && !c[16] && (r[15:0] < 16'(vr)) && (c[15:0] < 16'(vc));
	endfunction

	// cell (r,c) lives at r*MAX_COLS + c; only meaningful for on-screen positions
	function automatic logic [AW-1:0] cell_addr(input logic [15:0] r, input logic [15:0] c);
		cell_addr = AW'(r[RW-1:0]) * COLS_A + AW'(c[CW-1:0]);
	endfunction

	// ---------------------------------------------------------------- state
	state_t state_q, state_d;

	logic [6:0]  rows_q;
	logic [7:0]  cols_q;
	logic [3:0]  fore_q;
	logic [3:0]  back_q;
	logic        skip_q;

	logic [15:0] row_q;
	logic [15:0] col_q;
	logic [14:0] off_q;

	logic [255:0] remap_vld_q;

	logic [AW-1:0] init_addr_q;

	logic [RW-1:0]    clr_row_q;
	logic [CW-1:0]    clr_col_q;
	logic [AW-1:0]    clr_base_q;
	logic [VIS_W-1:0] clr_rows_q;
	logic [VIS_W-1:0] clr_cols_q;
	logic [7:0]       clr_attr_q;

	// put char stage
	logic          put_on_s1;
	logic [AW-1:0] put_addr_s1;
	logic          put_hit_s1;
	logic [7:0]    put_char_s1;

	// read cell stage
	logic rd_on_s1;

	logic       out_valid_q;
	logic [7:0] out_char_q;
	logic [7:0] out_attr_q;
	logic       out_in_range_q;

	// ---------------------------------------------------------------- datapath
	logic [VIS_W-1:0] vis_rows, vis_cols;
	logic [7:0]       attr;
	logic             acc;
	logic             in_ready;
	logic             out_load;

	assign vis_rows = ({2'b00, rows_q} > MAXR_V) ? MAXR_V : {2'b00, rows_q};
	assign vis_cols = ({1'b0, cols_q} > MAXC_V) ? MAXC_V : {1'b0, cols_q};
	assign attr     = {back_q, fore_q};
	assign acc      = req.valid && in_ready;

	// column of the next put: cursor column plus running offset, 17 bit signed
	logic [16:0] put_pos;
	assign put_pos = {col_q[15], col_q} + {2'b00, off_q};

	logic          rd_on;
	logic [AW-1:0] rd_addr;
	assign rd_on   = on_scr({req.pos_y[15], req.pos_y}, {req.pos_x[15], req.pos_x},
			vis_rows, vis_cols);
	assign rd_addr = cell_addr(req.pos_y, req.pos_x);

	// remap table: byte targets in RAM, valid bits in flops so a single request clears them all
	logic [7:0] remap_rdata;

	tcbw_ram #(
		.WIDTH (8),
		.DEPTH (256)
	) u_remap_ram (
		.clk   (clk),
		.we    (acc && (req.req_type == REQ_SET_REMAP)),
		.waddr (req.char_code),
		.wdata (req.remap_target),
		.re    (acc && (req.req_type == REQ_PUT)),
		.raddr (req.char_code),
		.rdata (remap_rdata)
	);

	logic [7:0] put_ch;
	logic       put_nl;
	logic       put_wr;

	assign put_ch = put_hit_s1 ? remap_rdata : put_char_s1;
	assign put_nl = (put_ch == NEWLINE_CHAR);
	assign put_wr = (state_q == ST_PUT) && !put_nl && put_on_s1
			&& !(skip_q && (put_ch == SPACE_CHAR));

	// cell store write port is shared by the reset sweep, clear and put
	logic          cell_we;
	logic [AW-1:0] cell_waddr;
	logic [15:0]   cell_wdata;
	logic [15:0]   cell_rdata;

	always_comb begin
		cell_we    = 1'b0;
		cell_waddr = put_addr_s1;
		cell_wdata = {attr, put_ch};
		case (state_q)
			ST_INIT: begin
				cell_we    = 1'b1;
				cell_waddr = init_addr_q;
				cell_wdata = '0;
			end
			ST_CLEAR: begin
				cell_we    = 1'b1;
				cell_waddr = clr_base_q + AW'(clr_col_q);
				cell_wdata = {clr_attr_q, SPACE_CHAR};
			end
			ST_PUT: begin
				cell_we = put_wr;
			end
			default: begin
				cell_we = 1'b0;
			end
		endcase
	end

	// read data stays put while a result waits, since nothing else reads
	tcbw_ram #(
		.WIDTH (16),
		.DEPTH (DEPTH)
	) u_cell_ram (
		.clk   (clk),
		.we    (cell_we),
		.waddr (cell_waddr),
		.wdata (cell_wdata),
		.re    (acc && (req.req_type == REQ_READ) && rd_on),
		.raddr (rd_addr),
		.rdata (cell_rdata)
	);

	logic clr_last_col, clr_last_row;
	assign clr_last_col = (VIS_W'(clr_col_q) + VIS_W'(1)) == clr_cols_q;
	assign clr_last_row = (VIS_W'(clr_row_q) + VIS_W'(1)) == clr_rows_q;

	// ---------------------------------------------------------------- FSM
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: begin
				if (init_addr_q == LAST_A) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (acc) begin
					case (req.req_type)
						REQ_PUT:   state_d = ST_PUT;
						REQ_READ:  state_d = ST_READ;
						REQ_CLEAR: begin
							// nothing visible: only the cursor is homed
							if ((vis_rows != '0) && (vis_cols != '0)) begin
								state_d = ST_CLEAR;
							end
						end
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_PUT: begin
				state_d = ST_IDLE;
			end
			ST_READ: begin
				if (!out_valid_q || rsp.ready) begin
					state_d = ST_IDLE;
				end
			end
			ST_CLEAR: begin
				if (clr_last_col && clr_last_row) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready = (state_q == ST_IDLE);
		out_load = (state_q == ST_READ) && (!out_valid_q || rsp.ready);
	end

	assign req.ready         = in_ready;
	assign rsp.valid         = out_valid_q;
	assign rsp.cell_char     = out_char_q;
	assign rsp.cell_attr     = out_attr_q;
	assign rsp.cell_in_range = out_in_range_q;

	// ---------------------------------------------------------------- control regs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			init_addr_q <= '0;
			clr_row_q   <= '0;
			clr_col_q   <= '0;
			clr_base_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			if (state_q == ST_INIT) begin
				init_addr_q <= init_addr_q + AW'(1);
			end

			if (acc && (req.req_type == REQ_CLEAR)) begin
				clr_row_q  <= '0;
				clr_col_q  <= '0;
				clr_base_q <= '0;
			end else if (state_q == ST_CLEAR) begin
				if (clr_last_col) begin
					clr_col_q  <= '0;
					clr_row_q  <= clr_row_q + RW'(1);
					clr_base_q <= clr_base_q + COLS_A;
				end else begin
					clr_col_q <= clr_col_q + CW'(1);
				end
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= 7'd25;
			cols_q <= 8'd80;
			fore_q <= 4'd7;
			back_q <= 4'd0;
			skip_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ROWS: rows_q <= cfg_data[6:0];
				CFG_COLS: cols_q <= cfg_data;
				CFG_FORE: fore_q <= cfg_data[3:0];
				CFG_BACK: back_q <= cfg_data[3:0];
				CFG_SKIP: skip_q <= cfg_data[0];
				default:  ;
			endcase
		end
	end

	// cursor and remap valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q       <= '0;
			col_q       <= '0;
			off_q       <= '0;
			remap_vld_q <= '0;
		end else begin
			if (acc) begin
				case (req.req_type)
					REQ_MOVE: begin
						row_q <= req.pos_y;
						col_q <= req.pos_x;
						off_q <= '0;
					end
					REQ_CLEAR: begin
						row_q <= '0;
						col_q <= '0;
						off_q <= '0;
					end
					REQ_SET_REMAP: begin
						remap_vld_q[req.char_code] <= 1'b1;
					end
					REQ_CLR_REMAPS: begin
						remap_vld_q <= '0;
					end
					default: ;
				endcase
			end else if (state_q == ST_PUT) begin
				if (put_nl) begin
					row_q <= row_q + 16'd1;
					off_q <= '0;
				end else if (off_q != OFFSET_LIMIT) begin
					off_q <= off_q + 15'd1;
				end
			end
		end
	end

	// ---------------------------------------------------------------- payload regs
	always_ff @(posedge clk) begin
		if (acc && (req.req_type == REQ_PUT)) begin
			put_on_s1   <= on_scr({row_q[15], row_q}, put_pos, vis_rows, vis_cols);
			put_addr_s1 <= cell_addr(row_q, put_pos[15:0]);
			put_hit_s1  <= remap_vld_q[req.char_code];
			put_char_s1 <= req.char_code;
		end
		if (acc && (req.req_type == REQ_READ)) begin
			rd_on_s1 <= rd_on;
		end
		if (acc && (req.req_type == REQ_CLEAR)) begin
			clr_rows_q <= vis_rows;
			clr_cols_q <= vis_cols;
			clr_attr_q <= attr;
		end
		if (out_load) begin
			out_char_q     <= rd_on_s1 ? cell_rdata[7:0]  : 8'd0;
			out_attr_q     <= rd_on_s1 ? cell_rdata[15:8] : 8'd0;
			out_in_range_q <= rd_on_s1;
		end
	end

	// ---------------------------------------------------------------- checks
`ifndef NO_ASSERTIONS
	a_read_goes_to_read: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && (req.req_type == REQ_READ)) |=> (state_q == ST_READ))
		else $error("read request did not enter the read state");

	a_result_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_READ))
		else $error("result raised outside a read");

	a_clear_in_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |->
			((VIS_W'(clr_row_q) < clr_rows_q) && (VIS_W'(clr_col_q) < clr_cols_q)))
		else $error("clear sweep outside the visible area");

	a_put_on_screen: assert property (@(posedge clk) disable iff (!arst_n)
		(cell_we && (state_q == ST_PUT)) |-> put_on_s1)
		else $error("put wrote an off-screen cell");

	a_init_ends: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_INIT) && (init_addr_q == LAST_A)) |=> (state_q == ST_IDLE))
		else $error("reset sweep did not finish");
`endif

endmodule

`default_nettype wire
